>>> rtl/ucp_pkg.sv
// Package: shared types, mode codes and policy lookup tables for the USB charge port policy.
`timescale 1ns / 1ps

package ucp_pkg;

  // Register map
  localparam int unsigned AddrWidth = 4;

  typedef enum logic [1:0] {
    REG_CHARGE_EN       = 2'd0,
    REG_SLEEP_CHARGE_EN = 2'd1,
    REG_DEBUG_LEVEL_EN  = 2'd2,
    REG_DEBUG_LEVEL     = 2'd3
  } reg_idx_e;

  // Port power modes
  typedef enum logic [2:0] {
    MODE_OFF = 3'd0,
    MODE_ON  = 3'd1,
    MODE_SDP = 3'd2,
    MODE_CDP = 3'd3,
    MODE_DCP = 3'd4
  } mode_e;

  // Collapsed system power state
  typedef enum logic [1:0] {
    SX_S0  = 2'd0,
    SX_S3  = 2'd1,
    SX_S45 = 2'd2
  } sx_e;

  // Raw system state codes
  localparam logic [3:0] ST_S5_TO_S0 = 4'd3;  // last code of the S0 group
  localparam logic [3:0] ST_S3       = 4'd4;
  localparam logic [3:0] ST_S0_TO_S3 = 4'd5;
  localparam logic [3:0] ST_DSX      = 4'd8;
  localparam logic [3:0] ST_S5_TO_DSX = 4'd11;

  // Debounce reload and battery thresholds
  localparam logic [5:0] DebounceLoad = 6'd61;
  localparam logic [6:0] LevelMax     = 7'd100;
  localparam logic [6:0] LevelBand1Hi = 7'd15;
  localparam logic [6:0] LevelBand1Lo = 7'd11;
  localparam logic [6:0] LevelBand2Hi = 7'd10;
  localparam logic [6:0] LevelBand3Hi = 7'd5;

  typedef struct packed {
    logic       charge_enable;
    logic       sleep_charge_enable;
    logic       debug_level_enable;
    logic [6:0] debug_level;
  } cfg_t;

  typedef struct packed {
    logic [3:0] sys_state;
    logic       ac_present;
    logic       detect_pin;
    logic [6:0] batt_level;
    logic       batt_ready;
    logic       thermal_shutdown;
    logic       usb_power_block;
  } item_t;

  typedef struct packed {
    mode_e      aou_mode;
    mode_e      other_mode;
    logic [6:0] power_type;
    logic       charger_enable_pin;
    logic       mode1_pin;
    logic       mode3_pin;
    logic       port_power_driven;
    logic       device_present;
  } result_t;

  function automatic sx_e sx_of(logic [3:0] st);
    sx_e sx;
    if (st <= ST_S5_TO_S0) begin
      sx = SX_S0;
    end else if (st == ST_S3 || st == ST_S0_TO_S3) begin
      sx = SX_S3;
    end else begin
      sx = SX_S45;
    end
    return sx;
  endfunction

  function automatic logic [1:0] band_of(logic [6:0] lvl);
    logic [1:0] band;
    if (lvl <= LevelBand3Hi) begin
      band = 2'd3;
    end else if (lvl <= LevelBand2Hi) begin
      band = 2'd2;
    end else if (lvl <= LevelBand1Hi && lvl >= LevelBand1Lo) begin
      band = 2'd1;
    end else begin
      band = 2'd0;
    end
    return band;
  endfunction

  // Enable-state tables. Rows: AC enabled, DC enabled, AC disabled, DC disabled
  function automatic mode_e aou_en_lookup(logic [1:0] row, sx_e sx);
    mode_e m;
    case (row) inside
      2'd0:       m = (sx == SX_S0) ? MODE_CDP : MODE_DCP;
      2'd1:       m = (sx == SX_S0) ? MODE_CDP : ((sx == SX_S3) ? MODE_DCP : MODE_OFF);
      2'd2, 2'd3: m = (sx == SX_S45) ? MODE_OFF : MODE_SDP;
      default:    m = MODE_OFF;
    endcase
    return m;
  endfunction

  function automatic mode_e oth_en_lookup(logic [1:0] row, sx_e sx);
    mode_e m;
    if (sx != SX_S45) begin
      m = MODE_SDP;
    end else if (row == 2'd0) begin
      m = MODE_ON;
    end else begin
      m = MODE_OFF;
    end
    return m;
  endfunction

  // Battery tables. Rows: S0, S3 dev, S3 no dev, S4/5 dev, S4/5 no dev
  function automatic mode_e aou_batt_lookup(logic [2:0] row, logic [1:0] band);
    mode_e m;
    case (row)
      3'd0: m = MODE_CDP;
      3'd1: begin
        case (band) inside
          2'd0, 2'd1: m = MODE_DCP;
          2'd2:       m = MODE_SDP;
          default:    m = MODE_OFF;
        endcase
      end
      3'd2: begin
        case (band) inside
          2'd0:       m = MODE_DCP;
          2'd1, 2'd2: m = MODE_SDP;
          default:    m = MODE_OFF;
        endcase
      end
      3'd3: m = (band <= 2'd1) ? MODE_DCP : MODE_OFF;
      3'd4: m = (band == 2'd0) ? MODE_DCP : MODE_OFF;
      default: m = MODE_OFF;
    endcase
    return m;
  endfunction

  function automatic mode_e oth_batt_lookup(logic [2:0] row, logic [1:0] band);
    mode_e m;
    case (row) inside
      3'd0:       m = MODE_SDP;
      3'd1, 3'd2: m = (band == 2'd3) ? MODE_OFF : MODE_SDP;
      default:    m = MODE_OFF;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/ucp_cfg_regs.sv
// APB configuration registers for the USB charge port policy.
`timescale 1ns / 1ps

module ucp_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ucp_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output ucp_pkg::cfg_t                 cfg_o
);
  import ucp_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_CHARGE_EN:       cfg_d.charge_enable       = pwdata[0];
        REG_SLEEP_CHARGE_EN: cfg_d.sleep_charge_enable = pwdata[0];
        REG_DEBUG_LEVEL_EN:  cfg_d.debug_level_enable  = pwdata[0];
        REG_DEBUG_LEVEL:     cfg_d.debug_level         = pwdata[6:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      REG_CHARGE_EN:       prdata = {31'd0, cfg_q.charge_enable};
      REG_SLEEP_CHARGE_EN: prdata = {31'd0, cfg_q.sleep_charge_enable};
      REG_DEBUG_LEVEL_EN:  prdata = {31'd0, cfg_q.debug_level_enable};
      REG_DEBUG_LEVEL:     prdata = {25'd0, cfg_q.debug_level};
      default:             prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/ucp_policy_core.sv
// Policy evaluation and per-tick state: debounce, mode lookup, overrides, pin levels.
`timescale 1ns / 1ps

module ucp_policy_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  ucp_pkg::item_t   item_i,
  input  ucp_pkg::cfg_t    cfg_i,
  output ucp_pkg::result_t result_o
);
  import ucp_pkg::*;

  logic [5:0] cnt_q, cnt_d;
  logic       flag_d;
  mode_e      last_aou_q, last_oth_q;
  logic       en_pin_q, en_pin_d;
  logic       m1_pin_q, m1_pin_d;
  logic       m3_pin_q, m3_pin_d;
  logic       pwr_pin_q, pwr_pin_d;

  sx_e        sx;
  logic       block_hit;
  logic       dbn_state;
  logic [1:0] en_row;
  logic [2:0] batt_row;
  logic [6:0] lvl;
  logic [1:0] band;
  mode_e      aou_tbl, oth_tbl, aou_fin, oth_fin;

  assign sx        = sx_of(item_i.sys_state);
  assign block_hit = item_i.usb_power_block && (item_i.sys_state == ST_S3) &&
                     !cfg_i.charge_enable;
  assign dbn_state = (item_i.sys_state == ST_S0_TO_S3) || (item_i.sys_state == ST_S3) ||
                     (item_i.sys_state == ST_DSX) || (item_i.sys_state == ST_S5_TO_DSX);

  // Detect pin debounce; count sticks at 1 once it gets there
  always_comb begin
    cnt_d  = cnt_q;
    flag_d = 1'b1;
    if (item_i.detect_pin) begin
      flag_d = 1'b0;
      if (dbn_state && cnt_q == 6'd0) begin
        cnt_d  = DebounceLoad;
        flag_d = 1'b1;
      end else if (cnt_q > 6'd1) begin
        cnt_d  = cnt_q - 6'd1;
        flag_d = 1'b1;
      end
    end
  end

  // Mode lookup
  always_comb begin
    en_row  = {!cfg_i.charge_enable, !item_i.ac_present};
    aou_tbl = aou_en_lookup(en_row, sx);
    oth_tbl = oth_en_lookup(en_row, sx);

    lvl = item_i.batt_level;
    if (cfg_i.debug_level_enable) begin
      lvl = (cfg_i.debug_level > LevelMax) ? LevelMax : cfg_i.debug_level;
    end
    band = band_of(lvl);

    unique case (sx)
      SX_S0:   batt_row = 3'd0;
      SX_S3:   batt_row = flag_d ? 3'd1 : 3'd2;
      default: batt_row = flag_d ? 3'd3 : 3'd4;
    endcase

    if (!item_i.ac_present && item_i.batt_ready && cfg_i.charge_enable) begin
      aou_tbl = aou_batt_lookup(batt_row, band);
      if (!cfg_i.sleep_charge_enable && sx == SX_S45) begin
        aou_tbl = MODE_OFF;
      end
      oth_tbl = oth_batt_lookup(batt_row, band);
    end

    // Thermal and BIOS overrides
    if (item_i.thermal_shutdown || block_hit) begin
      aou_fin = MODE_OFF;
      oth_fin = MODE_OFF;
    end else begin
      aou_fin = aou_tbl;
      oth_fin = oth_tbl;
    end
  end

  // Pin levels, re-driven only on a mode change
  always_comb begin
    en_pin_d  = en_pin_q;
    m1_pin_d  = m1_pin_q;
    m3_pin_d  = m3_pin_q;
    pwr_pin_d = pwr_pin_q;
    if (aou_fin != last_aou_q) begin
      case (aou_fin)
        MODE_OFF: begin
          en_pin_d = 1'b0; m1_pin_d = 1'b0; m3_pin_d = 1'b0;
        end
        MODE_SDP: begin
          en_pin_d = 1'b1; m1_pin_d = 1'b1; m3_pin_d = 1'b0;
        end
        MODE_CDP: begin
          en_pin_d = 1'b1; m1_pin_d = 1'b1; m3_pin_d = 1'b1;
        end
        MODE_DCP: begin
          en_pin_d = 1'b1; m1_pin_d = 1'b0; m3_pin_d = 1'b1;
        end
        default: ;
      endcase
    end
    if (oth_fin != last_oth_q) begin
      if (oth_fin == MODE_OFF) begin
        pwr_pin_d = 1'b0;
      end else if (oth_fin != MODE_ON) begin
        pwr_pin_d = 1'b1;
      end
      if (block_hit) begin
        pwr_pin_d = 1'b0;
      end
    end
  end

  // State update once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      last_aou_q <= MODE_OFF;
      last_oth_q <= MODE_OFF;
      en_pin_q   <= 1'b0;
      m1_pin_q   <= 1'b0;
      m3_pin_q   <= 1'b0;
      pwr_pin_q  <= 1'b0;
    end else if (step_i) begin
      cnt_q      <= cnt_d;
      last_aou_q <= aou_fin;
      last_oth_q <= oth_fin;
      en_pin_q   <= en_pin_d;
      m1_pin_q   <= m1_pin_d;
      m3_pin_q   <= m3_pin_d;
      pwr_pin_q  <= pwr_pin_d;
    end
  end

  // Result beat; power_type is aou*16 + other, taken before overrides
  always_comb begin
    result_o.aou_mode           = aou_fin;
    result_o.other_mode         = oth_fin;
    result_o.power_type         = {aou_tbl, 1'b0, oth_tbl};
    result_o.charger_enable_pin = en_pin_d;
    result_o.mode1_pin          = m1_pin_d;
    result_o.mode3_pin          = m3_pin_d;
    result_o.port_power_driven  = pwr_pin_d;
    result_o.device_present     = flag_d;
  end

endmodule

>>> rtl/usb_charge_port_power_policy_top.sv
// Top level of the USB charge port power policy: input register, policy core, result register.
`timescale 1ns / 1ps

// Evaluates the USB charge port power policy once per input beat. An accepted beat is
// held in the input register, evaluated combinationally against the debounce, mode and pin
// state, and written into the result register once that is empty or being drained. With
// the output side ready a beat is accepted every cycle. The input stalls only while both
// registers hold beats and the output side is not taking one; in_ready_o follows
// out_ready_i combinationally in that case.
// The policy state advances exactly once per beat as it moves into the result
// register. Configuration is through a small APB port: registers charge_enable,
// sleep_charge_enable, debug_level_enable and debug_level at byte offsets 0, 4, 8, 12.
module usb_charge_port_power_policy_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ucp_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [3:0]                    sys_state_i,
  input  logic                          ac_present_i,
  input  logic                          detect_pin_i,
  input  logic [6:0]                    batt_level_i,
  input  logic                          batt_ready_i,
  input  logic                          thermal_shutdown_i,
  input  logic                          usb_power_block_i,
  // Result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    aou_mode_o,
  output logic [2:0]                    other_mode_o,
  output logic [6:0]                    power_type_o,
  output logic                          charger_enable_pin_o,
  output logic                          mode1_pin_o,
  output logic                          mode3_pin_o,
  output logic                          port_power_driven_o,
  output logic                          device_present_o
);
  import ucp_pkg::*;

  cfg_t    cfg;
  item_t   in_q;
  logic    in_valid_q, in_valid_d;
  result_t res;
  result_t out_q;
  logic    out_valid_q, out_valid_d;
  logic    advance;
  logic    in_fire;

  ucp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake control
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q.sys_state        <= sys_state_i;
      in_q.ac_present       <= ac_present_i;
      in_q.detect_pin       <= detect_pin_i;
      in_q.batt_level       <= batt_level_i;
      in_q.batt_ready       <= batt_ready_i;
      in_q.thermal_shutdown <= thermal_shutdown_i;
      in_q.usb_power_block  <= usb_power_block_i;
    end
  end

  ucp_policy_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (res)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign aou_mode_o           = out_q.aou_mode;
  assign other_mode_o         = out_q.other_mode;
  assign power_type_o         = out_q.power_type;
  assign charger_enable_pin_o = out_q.charger_enable_pin;
  assign mode1_pin_o          = out_q.mode1_pin;
  assign mode3_pin_o          = out_q.mode3_pin;
  assign port_power_driven_o  = out_q.port_power_driven;
  assign device_present_o     = out_q.device_present;

endmodule
